// ===== rtl/core/rrr_pkg.sv =====
// Shared constants, types and helpers for the ray reflect/refract unit.
`default_nettype none
package rrr_pkg;

    // Fixed-point formats
    localparam int FRAC_BITS   = 14;                // direction fraction bits (Q2.14)
    localparam int RATIO_BITS  = 16;                // index ratio fraction bits
    localparam int RATIO_W     = RATIO_BITS + 2;    // ratio below 4.0
    localparam int INDEX_W     = 14;                // Q2.12 refractive index
    localparam int ROOT_W      = 20;                // sqrt result width
    localparam int COST2_W     = 26;                // non-negative cos_t^2 width
    localparam int SQRT_ARG_W  = COST2_W + FRAC_BITS;

    // Pipeline layout
    localparam int N_STAGES    = 24;
    localparam int DIV_STAGES  = 7;                 // 1 setup + 6 x 3 quotient bits
    localparam int DIV_BITS    = 3;
    localparam int SQRT_STAGES = 10;                // 2 root bits per stage
    localparam int SQRT_BITS   = 2;
    localparam int SQRT_FIRST  = 11;                // first sqrt stage index

    typedef enum logic {
        ACT_REFLECT = 1'b0,
        ACT_REFRACT = 1'b1
    } action_t;

    // Clamp to signed 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [15:0] r;
        if (v > 32'sd32767)
            r = 16'sh7FFF;
        else if (v < -32'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rrr_delay.sv =====
// Enable-gated shift line that keeps side data aligned with the pipeline.
`default_nettype none
module rrr_delay
    import rrr_pkg::*;
#(
    parameter int W = 1,
    parameter int N = 1
)(
    input  wire logic         clk,
    input  wire logic [N-1:0] en,
    input  wire logic [W-1:0] d,
    output logic      [W-1:0] q
);

    logic [W-1:0] stg_reg [N];

    // One register per pipeline stage, each moves with its stage enable
    always_ff @(posedge clk)
    begin
        if (en[0])
            stg_reg[0] <= d;
        for (int k = 1; k < N; k++)
        begin
            if (en[k])
                stg_reg[k] <= stg_reg[k-1];
        end
    end

    assign q = stg_reg[N-1];

endmodule
`default_nettype wire

// ===== rtl/core/rrr_div.sv =====
// Pipelined restoring divider for the index ratio, saturating at 4 - 2^-16.
`default_nettype none
module rrr_div
    import rrr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic [DIV_STAGES-1:0]  en,
    input  wire logic [INDEX_W-1:0]     outside_index,
    input  wire logic [INDEX_W-1:0]     inside_index,
    output logic      [RATIO_W-1:0]     ratio
);

    localparam int NUM_W = INDEX_W + RATIO_BITS + 1;
    localparam int CMP_W = NUM_W + 1;

    logic [NUM_W-1:0]   rem_reg [DIV_STAGES];
    logic [RATIO_W-1:0] quo_reg [DIV_STAGES];
    logic [INDEX_W-1:0] den_reg [DIV_STAGES];
    logic               ovf_reg [DIV_STAGES];

    logic [NUM_W-1:0] num;
    logic [CMP_W-1:0] lim;

    // Rounded numerator ext*2^16 + inn/2; quotient overflows past 18 bits
    always_comb
    begin
        num = NUM_W'({outside_index, RATIO_BITS'(0)}) + NUM_W'(inside_index >> 1);
        lim = CMP_W'(inside_index) << RATIO_W;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0] <= num;
            quo_reg[0] <= '0;
            den_reg[0] <= inside_index;
            ovf_reg[0] <= (CMP_W'(num) >= lim);
        end
    end

    // Each stage resolves three quotient bits, most significant first
    for (genvar j = 1; j < DIV_STAGES; j++)
    begin : g_stage
        localparam int TOP = RATIO_W - 1 - DIV_BITS * (j - 1);

        logic [NUM_W-1:0]   rem_next;
        logic [RATIO_W-1:0] quo_next;
        logic [CMP_W-1:0]   trial;

        always_comb
        begin
            rem_next = rem_reg[j-1];
            quo_next = quo_reg[j-1];
            trial    = '0;
            for (int s = 0; s < DIV_BITS; s++)
            begin
                trial = CMP_W'(den_reg[j-1]) << (TOP - s);
                if (CMP_W'(rem_next) >= trial)
                begin
                    rem_next = rem_next - NUM_W'(trial);
                    quo_next[TOP - s] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                rem_reg[j] <= rem_next;
                quo_reg[j] <= quo_next;
                den_reg[j] <= den_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
            end
        end
    end

    assign ratio = ovf_reg[DIV_STAGES-1] ? '1 : quo_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/core/rrr_sqrt.sv =====
// Pipelined digit-by-digit integer square root, two root bits per stage.
`default_nettype none
module rrr_sqrt
    import rrr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic [SQRT_STAGES-1:0] en,
    input  wire logic [SQRT_ARG_W-1:0]  arg,
    output logic      [ROOT_W-1:0]      root
);

    localparam int REM_W = SQRT_ARG_W + 1;

    logic [REM_W-1:0]  rem_reg  [SQRT_STAGES];
    logic [ROOT_W-1:0] root_reg [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_stage
        localparam int TOP = ROOT_W - 1 - SQRT_BITS * k;

        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;
        logic [REM_W-1:0]  trial;

        if (k == 0)
        begin : g_first
            assign rem_in  = REM_W'(arg);
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // Try setting bit b: subtract 2*root*2^b + 4^b from the remainder
        always_comb
        begin
            rem_next  = rem_in;
            root_next = root_in;
            trial     = '0;
            for (int s = 0; s < SQRT_BITS; s++)
            begin
                trial = (REM_W'(root_next) << (TOP - s + 1))
                      + (REM_W'(1) << (2 * (TOP - s)));
                if (rem_next >= trial)
                begin
                    rem_next = rem_next - trial;
                    root_next[TOP - s] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
            end
        end
    end

    assign root = root_reg[SQRT_STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/core/ray_reflect_refract_unit.sv =====
// Top level: pipelined mirror reflection and Snell refraction of a direction.
//
//   channel  | dir | tdata (low bit up)                                  | tuser
//   s_axis   | in  | in_x,in_y,in_z,normal_x,normal_y,normal_z,           | action
//            |     | outside_index,inside_index, 4 zero bits (128 bits)  |
//   m_axis   | out | out_x,out_y,out_z (48 bits)                          | total_internal
//
// One item enters per cycle while m_axis_tready is high or a stage is empty. Depth is set by the
// 7-stage ratio divider and the 10-stage square root in series.
// rst_n clears only the stage valid bits. Each stage holds while the next one
// is full and stalled; empty stages still fill, so bubbles close up.
`default_nettype none
module ray_reflect_refract_unit
    import rrr_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,   // in_x,in_y,in_z,normal_x,y,z,outside,inside
    input  wire logic         s_axis_tuser,   // action
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic      [47:0]  m_axis_tdata,   // out_x,out_y,out_z
    output logic              m_axis_tuser    // total_internal
);

    localparam int F  = FRAC_BITS;
    localparam int RB = RATIO_BITS;

    logic [N_STAGES-1:0] vld_reg;
    logic [N_STAGES-1:0] en;

    // Stage advance: a stage loads when empty or when its successor moves
    always_comb
    begin
        en[N_STAGES-1] = !vld_reg[N_STAGES-1] | m_axis_tready;
        for (int k = N_STAGES - 2; k >= 0; k--)
            en[k] = !vld_reg[k] | en[k+1];
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = vld_reg[N_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[0])
                vld_reg[0] <= s_axis_tvalid;
            for (int k = 1; k < N_STAGES; k++)
            begin
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Input unpacking
    logic signed [15:0] d_in  [3];
    logic signed [15:0] nv_in [3];
    logic [INDEX_W-1:0] ext_in, inn_in;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_in[i]  = s_axis_tdata[16*i +: 16];
            nv_in[i] = s_axis_tdata[48 + 16*i +: 16];
        end
        ext_in = s_axis_tdata[96 +: INDEX_W];
        inn_in = s_axis_tdata[96 + INDEX_W +: INDEX_W];
    end

    // Side data delay lines
    logic [47:0] d_pk_in, nv_pk_in, d_pk6, nv_pk21;
    logic        act22;
    logic signed [15:0] d6 [3], nv1 [3], nv21 [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_pk_in[16*i +: 16]  = d_in[i];
            nv_pk_in[16*i +: 16] = nv_in[i];
        end
    end

    rrr_delay #(.W(1), .N(23)) u_act_dly (
        .clk(clk), .en(en[22:0]), .d(s_axis_tuser), .q(act22));
    rrr_delay #(.W(48), .N(7)) u_d_dly (
        .clk(clk), .en(en[6:0]), .d(d_pk_in), .q(d_pk6));
    rrr_delay #(.W(48), .N(22)) u_nv_dly (
        .clk(clk), .en(en[21:0]), .d(nv_pk_in), .q(nv_pk21));

    // Stage 0: component products for the dot product
    logic signed [31:0] p0_reg  [3];
    logic signed [15:0] d0_reg  [3];
    logic signed [15:0] nv0_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                p0_reg[i]  <= 32'(d_in[i]) * 32'(nv_in[i]);
                d0_reg[i]  <= d_in[i];
                nv0_reg[i] <= nv_in[i];
            end
        end
    end

    // Ratio divider, stages 0..6
    logic [RATIO_W-1:0] n6;

    rrr_div u_div (
        .clk(clk), .en(en[DIV_STAGES-1:0]),
        .outside_index(ext_in), .inside_index(inn_in), .ratio(n6));

    // Stage 1: dot product
    logic signed [33:0] dot1_reg;
    logic signed [15:0] d1_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            dot1_reg <= 34'(p0_reg[0]) + 34'(p0_reg[1]) + 34'(p0_reg[2]);
            for (int i = 0; i < 3; i++)
            begin
                d1_reg[i] <= d0_reg[i];
                nv1[i]    <= nv0_reg[i];
            end
        end
    end

    // Stage 2: reflect products and cos_i
    logic signed [34:0] dot2x, ncos_sum, ncos_sh;
    logic signed [19:0] cos_i_next;
    logic signed [19:0] cos2_reg;
    logic signed [50:0] rp2_reg [3];
    logic signed [15:0] d2_reg  [3];

    always_comb
    begin
        dot2x      = 35'(dot1_reg) <<< 1;
        ncos_sum   = -35'(dot1_reg) + (35'sd1 <<< (F - 1));
        ncos_sh    = ncos_sum >>> F;
        cos_i_next = ncos_sh[19:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            cos2_reg <= cos_i_next;
            for (int i = 0; i < 3; i++)
            begin
                rp2_reg[i] <= 51'(dot2x) * 51'(nv1[i]);
                d2_reg[i]  <= d1_reg[i];
            end
        end
    end

    // Stage 3: reflect result and cos_i squared
    logic signed [50:0] rp_sum [3];
    logic signed [50:0] rp_sh  [3];
    logic signed [31:0] refl_diff [3];
    logic signed [15:0] refl3_reg [3];
    logic signed [39:0] c2p3_reg;
    logic [47:0]        refl_pk3, refl_pk22;
    logic signed [15:0] refl22 [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rp_sum[i]    = rp2_reg[i] + (51'sd1 <<< (2*F - 1));
            rp_sh[i]     = rp_sum[i] >>> (2*F);
            refl_diff[i] = 32'(d2_reg[i]) - 32'($signed(rp_sh[i][22:0]));
            refl_pk3[16*i +: 16] = refl3_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            c2p3_reg <= 40'(cos2_reg) * 40'(cos2_reg);
            for (int i = 0; i < 3; i++)
                refl3_reg[i] <= sat16(refl_diff[i]);
        end
    end

    rrr_delay #(.W(48), .N(19)) u_refl_dly (
        .clk(clk), .en(en[22:4]), .d(refl_pk3), .q(refl_pk22));

    logic [19:0] cos_pk6;
    logic signed [19:0] cos6;

    rrr_delay #(.W(20), .N(4)) u_cos_dly (
        .clk(clk), .en(en[6:3]), .d(cos2_reg), .q(cos_pk6));
    assign cos6 = cos_pk6;

    // Stage 4: s2 = 1 - cos_i^2
    logic signed [39:0] c2_sum, c2_sh;
    logic signed [23:0] s2_next;
    logic [23:0]        s2_pk8;
    logic signed [23:0] s2_8;

    always_comb
    begin
        c2_sum  = c2p3_reg + (40'sd1 <<< (F - 1));
        c2_sh   = c2_sum >>> F;
        s2_next = (24'sd1 <<< F) - c2_sh[23:0];
    end

    rrr_delay #(.W(24), .N(5)) u_s2_dly (
        .clk(clk), .en(en[8:4]), .d(s2_next), .q(s2_pk8));
    assign s2_8 = s2_pk8;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d6[i]   = d_pk6[16*i +: 16];
            nv21[i] = nv_pk21[16*i +: 16];
            refl22[i] = refl_pk22[16*i +: 16];
        end
    end

    // Stage 7: ratio products
    logic [35:0]        nn7_reg;
    logic signed [38:0] ncos7_reg;
    logic signed [34:0] nd7_reg [3];
    logic signed [18:0] n_s;

    assign n_s = {1'b0, n6};

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            nn7_reg   <= 36'(n6) * 36'(n6);
            ncos7_reg <= 39'(n_s) * 39'(cos6);
            for (int i = 0; i < 3; i++)
                nd7_reg[i] <= 35'(n_s) * 35'(d6[i]);
        end
    end

    // Stage 8: round the ratio products
    logic [35:0]        nn_sum;
    logic signed [38:0] ncos_r_sum, ncos_r_sh;
    logic signed [34:0] nd_sum [3];
    logic signed [34:0] nd_sh  [3];
    logic [20:0]        n2_8_reg;
    logic signed [22:0] ncr_next;
    logic [56:0]        ndr_pk;
    logic [22:0]        ncr_pk20;
    logic [56:0]        ndr_pk22;

    always_comb
    begin
        nn_sum     = nn7_reg + (36'd1 << (RB - 1));
        ncos_r_sum = ncos7_reg + (39'sd1 <<< (RB - 1));
        ncos_r_sh  = ncos_r_sum >>> RB;
        ncr_next   = ncos_r_sh[22:0];
        for (int i = 0; i < 3; i++)
        begin
            nd_sum[i] = nd7_reg[i] + (35'sd1 <<< (RB - 1));
            nd_sh[i]  = nd_sum[i] >>> RB;
            ndr_pk[19*i +: 19] = nd_sh[i][18:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[8])
            n2_8_reg <= 21'(nn_sum >> RB);
    end

    rrr_delay #(.W(23), .N(13)) u_ncr_dly (
        .clk(clk), .en(en[20:8]), .d(ncr_next), .q(ncr_pk20));
    rrr_delay #(.W(57), .N(15)) u_ndr_dly (
        .clk(clk), .en(en[22:8]), .d(ndr_pk), .q(ndr_pk22));

    // Stage 9: n^2 * sin_i^2
    logic signed [45:0] t9_reg;

    always_ff @(posedge clk)
    begin
        if (en[9])
            t9_reg <= 46'($signed({1'b0, n2_8_reg})) * 46'(s2_8);
    end

    // Stage 10: cos_t^2, total internal reflection test, sqrt argument
    logic signed [45:0]      t_sum, t_sh;
    logic signed [29:0]      cost2;
    logic                    tir_next;
    logic [COST2_W-1:0]      arg10_reg;
    logic                    tir22;

    always_comb
    begin
        t_sum    = t9_reg + (46'sd1 <<< (RB - 1));
        t_sh     = t_sum >>> RB;
        cost2    = (30'sd1 <<< F) - t_sh[29:0];
        tir_next = cost2[29];
    end

    always_ff @(posedge clk)
    begin
        if (en[10])
            arg10_reg <= tir_next ? '0 : cost2[COST2_W-1:0];
    end

    rrr_delay #(.W(1), .N(13)) u_tir_dly (
        .clk(clk), .en(en[22:10]), .d(tir_next), .q(tir22));

    // Stages 11..20: square root
    logic [ROOT_W-1:0] root20;

    rrr_sqrt u_sqrt (
        .clk(clk), .en(en[SQRT_FIRST + SQRT_STAGES - 1 : SQRT_FIRST]),
        .arg({arg10_reg, F'(0)}), .root(root20));

    // Stage 21: normal coefficient
    logic signed [23:0] coef21_reg;
    logic signed [22:0] ncr20;

    assign ncr20 = ncr_pk20;

    always_ff @(posedge clk)
    begin
        if (en[21])
            coef21_reg <= 24'(ncr20) - 24'($signed({1'b0, root20}));
    end

    // Stage 22: coefficient times normal
    logic signed [39:0] cp22_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[22])
        begin
            for (int i = 0; i < 3; i++)
                cp22_reg[i] <= 40'(coef21_reg) * 40'(nv21[i]);
        end
    end

    // Stage 23: final sum, action select, output register
    logic signed [39:0] cp_sum [3];
    logic signed [39:0] cp_sh  [3];
    logic signed [18:0] ndr22  [3];
    logic signed [31:0] fin    [3];
    logic signed [15:0] out_next [3];
    logic               ti_next;
    logic signed [15:0] out_reg [3];
    logic               ti_reg;

    always_comb
    begin
        ti_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            cp_sum[i] = cp22_reg[i] + (40'sd1 <<< (F - 1));
            cp_sh[i]  = cp_sum[i] >>> F;
            ndr22[i]  = ndr_pk22[19*i +: 19];
            fin[i]    = 32'(ndr22[i]) + 32'($signed(cp_sh[i][25:0]));
            out_next[i] = sat16(fin[i]);
        end
        if (action_t'(act22) == ACT_REFLECT)
        begin
            for (int i = 0; i < 3; i++)
                out_next[i] = refl22[i];
        end
        else if (tir22)
        begin
            ti_next = 1'b1;
            for (int i = 0; i < 3; i++)
                out_next[i] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[23])
        begin
            ti_reg <= ti_next;
            for (int i = 0; i < 3; i++)
                out_reg[i] <= out_next[i];
        end
    end

    assign m_axis_tdata = {out_reg[2], out_reg[1], out_reg[0]};
    assign m_axis_tuser = ti_reg;

endmodule
`default_nettype wire

// ===== tb/ray_reflect_refract_unit_tb.sv =====
// Testbench for ray_reflect_refract_unit: random reflect/refract items checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none

module ray_reflect_refract_unit_tb;
    import rrr_pkg::*;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               tir;
    } hit_result_t;

    // Mirror/Snell predictor plus queue of pending results
    class bend_scoreboard;
        hit_result_t pending[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        static function longint rnd_shift(longint v, int s);
            return (v + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        static function longint clamp16(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        static function longint int_sqrt(longint v);
            longint r;
            longint b;
            r = 0;
            b = longint'(1) <<< 62;
            while (b > v) b = b >>> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >>> 1) + b;
                end
                else
                    r = r >>> 1;
                b = b >>> 2;
            end
            return r;
        endfunction

        function void note_hit(action_t act, logic signed [15:0] d[3],
                               logic signed [15:0] nv[3], logic [13:0] ext,
                               logic [13:0] inn);
            hit_result_t res;
            longint dotv, n, cos_i, c2, n2, cos_t2, root, coef, one;
            longint r[3];
            dotv = longint'(d[0]) * nv[0] + longint'(d[1]) * nv[1] + longint'(d[2]) * nv[2];
            res.tir = 1'b0;
            if (act == ACT_REFLECT)
            begin
                for (int i = 0; i < 3; i++)
                    r[i] = clamp16(d[i] - rnd_shift(2 * dotv * nv[i], 2 * FRAC_BITS));
            end
            else
            begin
                if (inn == 0)
                    n = (longint'(4) <<< RATIO_BITS) - 1;
                else
                begin
                    n = ((longint'(ext) <<< RATIO_BITS) + inn / 2) / inn;
                    if (n > (longint'(4) <<< RATIO_BITS) - 1)
                        n = (longint'(4) <<< RATIO_BITS) - 1;
                end
                one = longint'(1) <<< FRAC_BITS;
                cos_i = rnd_shift(-dotv, FRAC_BITS);
                c2 = rnd_shift(cos_i * cos_i, FRAC_BITS);
                n2 = rnd_shift(n * n, RATIO_BITS);
                cos_t2 = one - rnd_shift(n2 * (one - c2), RATIO_BITS);
                if (cos_t2 < 0)
                begin
                    res.tir = 1'b1;
                    r[0] = 0;
                    r[1] = 0;
                    r[2] = 0;
                end
                else
                begin
                    root = int_sqrt(cos_t2 <<< FRAC_BITS);
                    coef = rnd_shift(n * cos_i, RATIO_BITS) - root;
                    for (int i = 0; i < 3; i++)
                        r[i] = clamp16(rnd_shift(n * d[i], RATIO_BITS)
                                       + rnd_shift(coef * nv[i], FRAC_BITS));
                end
            end
            res.x = r[0][15:0];
            res.y = r[1][15:0];
            res.z = r[2][15:0];
            pending.push_back(res);
        endfunction

        function void check_result(logic [47:0] data, logic tir);
            hit_result_t exp_r;
            if (pending.size() == 0)
            begin
                $error("unexpected result %h tir %b", data, tir);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (data[15:0] !== exp_r.x)
            begin
                $error("out_x: expected %0d, got %0d", exp_r.x, $signed(data[15:0]));
                errors++;
            end
            if (data[31:16] !== exp_r.y)
            begin
                $error("out_y: expected %0d, got %0d", exp_r.y, $signed(data[31:16]));
                errors++;
            end
            if (data[47:32] !== exp_r.z)
            begin
                $error("out_z: expected %0d, got %0d", exp_r.z, $signed(data[47:32]));
                errors++;
            end
            if (tir !== exp_r.tir)
            begin
                $error("total_internal: expected %b, got %b", exp_r.tir, tir);
                errors++;
            end
        endfunction
    endclass

    localparam int RANDOM_ITEMS = 1830;
    localparam longint CYCLE_LIMIT = 400000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;   // in_x,in_y,in_z,normal_x,y,z,outside,inside
    logic         s_axis_tuser;   // action
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;   // out_x,out_y,out_z
    logic         m_axis_tuser;   // total_internal

    bend_scoreboard sb;
    bit             stim_done;
    longint         cycles;

    ray_reflect_refract_unit dut (.*);

    // Clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Send one hit, then wait a random gap
    task automatic send_hit(action_t act, logic signed [15:0] d[3],
                            logic signed [15:0] nv[3], logic [13:0] ext, logic [13:0] inn);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {4'b0, inn, ext, nv[2], nv[1], nv[0], d[2], d[1], d[0]};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_hit(act, d, nv, ext, inn);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        @(negedge clk);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Random unit-ish vector or arbitrary raw value
    function automatic logic signed [15:0] comp(bit wild);
        if (wild)
            return 16'($urandom());
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic logic [13:0] index_val();
        case ($urandom_range(0, 9))
            0: return 14'd0;
            1: return 14'($urandom());
            2: return 14'h3FFF;
            default: return 14'($urandom_range(4096, 8192));
        endcase
    endfunction

    // Stimulus
    initial
    begin
        logic signed [15:0] d[3];
        logic signed [15:0] nv[3];
        bit wild;
        sb = new();
        stim_done = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, normal incidence, grazing, total internal reflection
        d = '{16'sh0000, 16'sh0000, -16'sd16384};
        nv = '{16'sh0000, 16'sh0000, 16'sd16384};
        send_hit(ACT_REFLECT, d, nv, 14'd4096, 14'd4096);
        send_hit(ACT_REFRACT, d, nv, 14'd4096, 14'd6144);
        send_hit(ACT_REFRACT, d, nv, 14'd6144, 14'd4096);
        d = '{16'sd16384, 16'sh0000, -16'sd100};
        send_hit(ACT_REFRACT, d, nv, 14'd6144, 14'd4096);
        send_hit(ACT_REFRACT, d, nv, 14'h3FFF, 14'd4096);
        send_hit(ACT_REFRACT, d, nv, 14'd4096, 14'h3FFF);
        send_hit(ACT_REFRACT, d, nv, 14'd5000, 14'd0);
        d = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
        nv = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
        send_hit(ACT_REFLECT, d, nv, 14'd4096, 14'd4096);
        send_hit(ACT_REFRACT, d, nv, 14'd4096, 14'd4096);
        d = '{-16'sd32768, -16'sd32768, -16'sd32768};
        send_hit(ACT_REFLECT, d, nv, 14'h3FFF, 14'h3FFF);
        send_hit(ACT_REFRACT, d, nv, 14'h3FFF, 14'h2AAA);
        nv = '{-16'sd32768, -16'sd32768, -16'sd32768};
        send_hit(ACT_REFLECT, d, nv, 14'h1555, 14'h2AAA);
        send_hit(ACT_REFRACT, d, nv, 14'h1555, 14'h2AAA);

        // Hold off until the pipeline drains
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);

        // Random part
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            wild = ($urandom_range(0, 7) == 0);
            for (int i = 0; i < 3; i++)
            begin
                d[i] = comp(wild);
                nv[i] = comp(wild);
            end
            send_hit(action_t'($urandom_range(0, 1)), d, nv, index_val(), index_val());
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1;
    end

    // Result side: random stalls, sample at rising edge
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // End of run and timeout
    initial
    begin
        cycles = 0;
        wait (sb != null);
        while (!(stim_done && sb.pending.size() == 0) && cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("** ray_reflect_refract_unit: FAILED **");
            $finish;
        end
        else
        begin
            repeat (60) @(posedge clk);
            if (sb.errors == 0)
                $display("** ray_reflect_refract_unit: PASSED **");
            else
                $display("** ray_reflect_refract_unit: FAILED **");
            $finish;
        end
    end

endmodule

`default_nettype wire
